/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, ignored while reset is high
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Clocked assertion that also holds across reset
`define ASSERT_CLK_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed during or after reset");

`endif

/* src/lrfq_pkg.sv */
// ----------------------------------------------------------------------------
// lrfq_pkg
// Types and constants for the fourth-quadrant line rasteriser.
// ----------------------------------------------------------------------------
package lrfq_pkg;

  localparam int COORD_BITS = 12;
  localparam int TWICE_BITS = COORD_BITS + 2;
  localparam int ERR_BITS   = COORD_BITS + 3;

  typedef logic [COORD_BITS-1:0]      coord_t;
  typedef logic [TWICE_BITS-1:0]      twice_t;
  typedef logic signed [ERR_BITS-1:0] err_t;

  typedef enum logic {
    FN_LOAD = 1'b0,
    FN_STEP = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_PIXEL    = 2'd0,
    ST_IDLE     = 2'd1,
    ST_QUADRANT = 2'd2
  } status_t;

  typedef struct packed {
    coord_t  pixel_x;
    coord_t  pixel_y;
    logic    last_pixel;
    status_t status;
  } result_t;

endpackage

/* src/lrfq_core.sv */
// ----------------------------------------------------------------------------
// lrfq_core
// Line state; loads a line or takes one Bresenham step per accepted request.
// ----------------------------------------------------------------------------
module lrfq_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  logic             func,
  input  lrfq_pkg::coord_t x_start,
  input  lrfq_pkg::coord_t y_start,
  input  lrfq_pkg::coord_t x_end,
  input  lrfq_pkg::coord_t y_end,
  output lrfq_pkg::result_t result
);
  import lrfq_pkg::*;

  coord_t cur_col, cur_row, end_col, end_row;
  twice_t twice_dx, twice_dy;
  err_t   error_term;
  logic   row_major, line_active;

  coord_t cur_col_next, cur_row_next, end_col_next, end_row_next;
  twice_t twice_dx_next, twice_dy_next;
  err_t   error_term_next;
  logic   row_major_next, line_active_next;

  coord_t dx, dy, end_row_inc, start_col_inc, step_col_inc, step_row_dec, step_end_inc;
  err_t   err_add, err_sub, ext_dx, ext_dy;
  logic   wrong_quadrant, start_rm, start_last, step_last;

  always_comb begin
    cur_col_next     = cur_col;
    cur_row_next     = cur_row;
    end_col_next     = end_col;
    end_row_next     = end_row;
    twice_dx_next    = twice_dx;
    twice_dy_next    = twice_dy;
    error_term_next  = error_term;
    row_major_next   = row_major;
    line_active_next = line_active;
    step_last        = 1'b0;
    result           = '{pixel_x: '0, pixel_y: '0, last_pixel: 1'b0, status: ST_IDLE};

    dx             = x_end - x_start;
    dy             = y_start - y_end;
    wrong_quadrant = (x_end < x_start) || (y_end > y_start);
    start_rm       = dx < dy;
    end_row_inc    = y_end + coord_t'(1);
    start_col_inc  = x_start + coord_t'(1);
    start_last     = ((dx == '0) && (dy == '0)) ||
                     (start_rm ? (y_start == end_row_inc) : (start_col_inc == x_end));

    ext_dx       = err_t'({1'b0, twice_dx});
    ext_dy       = err_t'({1'b0, twice_dy});
    step_col_inc = cur_col + coord_t'(1);
    step_row_dec = cur_row - coord_t'(1);
    err_add      = error_term + ext_dx;
    err_sub      = error_term - ext_dy;
    step_end_inc = end_row + coord_t'(1);

    if (func == FN_LOAD) begin
      if (wrong_quadrant) begin
        line_active_next = 1'b0;
        result.status    = ST_QUADRANT;
      end else begin
        cur_col_next     = x_start;
        cur_row_next     = y_start;
        end_col_next     = x_end;
        end_row_next     = y_end;
        twice_dx_next    = {1'b0, dx, 1'b0};
        twice_dy_next    = {1'b0, dy, 1'b0};
        row_major_next   = start_rm;
        error_term_next  = start_rm ? -err_t'({3'b000, dy}) : err_t'({3'b000, dx});
        line_active_next = !start_last;
        result = '{pixel_x: x_start, pixel_y: y_start, last_pixel: start_last,
                   status: ST_PIXEL};
      end
    end else if (line_active) begin
      if (row_major) begin
        // minor step on column when the error goes positive
        cur_row_next = step_row_dec;
        if (err_add > 0) begin
          cur_col_next    = step_col_inc;
          error_term_next = err_add - ext_dy;
        end else begin
          error_term_next = err_add;
        end
      end else begin
        cur_col_next = step_col_inc;
        if (err_sub < 0) begin
          cur_row_next    = step_row_dec;
          error_term_next = err_sub + ext_dx;
        end else begin
          error_term_next = err_sub;
        end
      end
      step_last        = row_major ? (cur_row_next == step_end_inc)
                                   : ((cur_col_next + coord_t'(1)) == end_col);
      line_active_next = !step_last;
      result = '{pixel_x: cur_col_next, pixel_y: cur_row_next, last_pixel: step_last,
                 status: ST_PIXEL};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col     <= '0;
      cur_row     <= '0;
      end_col     <= '0;
      end_row     <= '0;
      twice_dx    <= '0;
      twice_dy    <= '0;
      error_term  <= '0;
      row_major   <= 1'b0;
      line_active <= 1'b0;
    end else if (fire) begin
      cur_col     <= cur_col_next;
      cur_row     <= cur_row_next;
      end_col     <= end_col_next;
      end_row     <= end_row_next;
      twice_dx    <= twice_dx_next;
      twice_dy    <= twice_dy_next;
      error_term  <= error_term_next;
      row_major   <= row_major_next;
      line_active <= line_active_next;
    end
  end

endmodule

/* src/lrfq_out.sv */
// ----------------------------------------------------------------------------
// lrfq_out
// Result register with valid/ready; takes a request while a result drains.
// ----------------------------------------------------------------------------
module lrfq_out (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              fire,
  input  lrfq_pkg::result_t result_in,
  output logic              out_valid,
  input  logic              out_ready,
  output lrfq_pkg::result_t result_out
);
  import lrfq_pkg::*;

  assign in_ready = !out_valid || out_ready;
  assign fire     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (fire) begin
      result_out <= result_in;
    end
  end

endmodule

/* src/line_raster_fourth_quadrant.sv */
// ----------------------------------------------------------------------------
// line_raster_fourth_quadrant
// Bresenham line stepper for lines running right and up (row falls).
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): a request with func 0 loads a line from
// (x_start, y_start) to (x_end, y_end) and returns the start pixel; func 1
// returns the next pixel. The end point itself is returned only by a load with start
// equal to end; the final pixel carries last_pixel. Status 1 marks a step with no
// line active, status 2 a load whose end lies left of or below the start.
// Output channel (out_valid/out_ready): exactly one result per request.
// The result enters the output register at the edge that takes the request.
// Throughput is one request per cycle while the receiver does not stall; the
// step is a single pass of two error-term adds between state and result
// register.
// While the receiver stalls, the held result stays and in_ready drops until
// it is taken; in_ready stays high while the output register drains.
// Reset clears the line state (no line active) and empties the output.
// ----------------------------------------------------------------------------
module line_raster_fourth_quadrant (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                func,
  input  lrfq_pkg::coord_t    x_start,
  input  lrfq_pkg::coord_t    y_start,
  input  lrfq_pkg::coord_t    x_end,
  input  lrfq_pkg::coord_t    y_end,
  output logic                out_valid,
  input  logic                out_ready,
  output lrfq_pkg::coord_t    pixel_x,
  output lrfq_pkg::coord_t    pixel_y,
  output logic                last_pixel,
  output lrfq_pkg::status_t   status
);
  import lrfq_pkg::*;

  logic    fire;
  result_t step_result, held_result;

  lrfq_core u_core (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .func    (func),
    .x_start (x_start),
    .y_start (y_start),
    .x_end   (x_end),
    .y_end   (y_end),
    .result  (step_result)
  );

  lrfq_out u_out (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .fire       (fire),
    .result_in  (step_result),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result_out (held_result)
  );

  assign pixel_x    = held_result.pixel_x;
  assign pixel_y    = held_result.pixel_y;
  assign last_pixel = held_result.last_pixel;
  assign status     = held_result.status;

endmodule

/* src/lrfq_checker.sv */
// ----------------------------------------------------------------------------
// lrfq_checker
// Port-level checks for the line rasteriser, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lrfq_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input lrfq_pkg::coord_t    pixel_x,
  input lrfq_pkg::coord_t    pixel_y,
  input logic                last_pixel,
  input lrfq_pkg::status_t   status
);
  import lrfq_pkg::*;

  // every taken request shows a result on the next edge
  `ASSERT_CLK(a_req_gives_result, (in_valid && in_ready) |=> out_valid)
  // an empty output register never blocks requests
  `ASSERT_CLK(a_ready_when_empty, !out_valid |-> in_ready)
  // error results carry no pixel
  `ASSERT_CLK(a_error_zero, (out_valid && status != ST_PIXEL) |->
    (pixel_x == '0 && pixel_y == '0 && !last_pixel))
  // stalled result holds
  `ASSERT_CLK(a_stall_hold, (out_valid && !out_ready) |=>
    (out_valid && $stable(pixel_x) && $stable(pixel_y) && $stable(last_pixel)
     && $stable(status)))
  `ASSERT_CLK_RST(a_reset_empty, rst |=> !out_valid)

endmodule

bind line_raster_fourth_quadrant lrfq_checker u_lrfq_checker (.*);
